// File: src/isiq_pkg.sv
package isiq_pkg;

  // Field widths of one transaction
  localparam int unsigned TIME_W = 15;
  localparam int unsigned OP_W = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Default table depth
  localparam int unsigned MAX_INTERVALS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  // Update applied to every cell in the commit cycle
  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_CLEAR,
    UPD_INSERT,
    UPD_JOIN_PREV,
    UPD_JOIN_NEXT,
    UPD_MERGE
  } upd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] stop;
  } span_t;

  typedef struct packed {
    logic  valid;
    span_t span;
  } cell_data_t;

  // Broadcast to all cells: update kind and request times
  typedef struct packed {
    upd_e              kind;
    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] t2;
  } cell_ctrl_t;

  // Where a cell sits relative to the insert position
  typedef struct packed {
    logic at_pos;
    logic pre_pos;
    logic after_pos;
  } cell_pos_t;

  // Registered compare results of one cell
  typedef struct packed {
    logic valid;
    logic pass_ins;
    logic pass_qry;
    logic in_start;
    logic eq_prev;
    logic eq_next;
  } cell_flags_t;

endpackage

// File: src/isiq_if.sv
interface isiq_req_if;
  import isiq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [TIME_W-1:0]          start_req;
  logic [TIME_W-1:0]          stop;

  modport source (output valid, operation, start_req, stop, input ready);
  modport sink (input valid, operation, start_req, stop, output ready);
endinterface

interface isiq_rsp_if;
  import isiq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic                       dropped_full;
  logic [COUNT_OUT_W-1:0]     entry_count;

  modport source (output valid, hit, dropped_full, entry_count, input ready);
  modport sink (input valid, hit, dropped_full, entry_count, output ready);
endinterface

// File: src/interval_set_insert_query_unit.sv
// Channel | Port  | Direction | Payload
// request | req_i | in        | operation, start_req, stop
// result  | rsp_o | out       | hit, dropped_full, entry_count
//
// Each transaction passes a compare state, where every cell compares its
// interval with the request, then an update state, where the position decoder
// drives the shift or update of all cells and loads the result register.
// A new request is taken in the update cycle of the previous one.
// Reset clears the occupancy bits and the count; interval times are not reset.
// A result waiting in the output register stalls only the next update cycle.
module interval_set_insert_query_unit import isiq_pkg::*; #(
  parameter int unsigned MaxIntervals = MAX_INTERVALS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  isiq_req_if.sink   req_i,
  isiq_rsp_if.source rsp_o
);

  localparam int unsigned CountW = $clog2(MaxIntervals + 1);

  state_e state_q, state_d;

  logic              in_fire;
  logic              out_free;
  logic              commit;

  // Request register
  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] t1_q;
  logic [TIME_W-1:0] t2_q;

  logic [CountW-1:0] count_q, count_d;

  logic                   out_valid_q, out_valid_d;
  logic                   hit_q, hit_d;
  logic                   dropped_q, dropped_d;
  logic [COUNT_OUT_W-1:0] entry_count_q;

  cell_data_t  cdata  [MaxIntervals];
  cell_flags_t cflags [MaxIntervals];
  cell_ctrl_t  ctrl;
  upd_e        kind;

  logic [MaxIntervals:0]   ins_pass, ins_first, ins_below;
  logic [MaxIntervals:0]   qry_pass, qry_first;
  logic [MaxIntervals-1:0] valid_vec, eq_prev_vec, eq_next_vec, in_start_vec;
  logic [MaxIntervals-1:0] occ_vec;
  logic                    join_prev, join_next, full, query_hit;

  // Handshake
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign commit      = (state_q == S_UPD) && out_free;
  assign req_i.ready = (state_q == S_IDLE) || commit;
  assign in_fire     = req_i.valid && req_i.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_fire) state_d = S_CMP;
      S_CMP:  state_d = S_UPD;
      S_UPD:  if (commit) state_d = in_fire ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Gather per-cell flags into vectors
  assign ins_pass[MaxIntervals] = 1'b0;
  assign qry_pass[MaxIntervals] = 1'b0;
  for (genvar i = 0; i < MaxIntervals; i++) begin : g_vec
    assign ins_pass[i]     = cflags[i].pass_ins;
    assign qry_pass[i]     = cflags[i].pass_qry;
    assign valid_vec[i]    = cflags[i].valid;
    assign eq_prev_vec[i]  = cflags[i].eq_prev;
    assign eq_next_vec[i]  = cflags[i].eq_next;
    assign in_start_vec[i] = cflags[i].in_start;
    // Live occupancy of each cell
    assign occ_vec[i]      = cdata[i].valid;
  end

  // Locate first failing cell: one-hot and the mask of cells in front of it
  assign ins_first = ~ins_pass & (ins_pass + 1'b1);
  assign ins_below = (ins_pass ^ (ins_pass + 1'b1)) & ins_pass;
  assign qry_first = ~qry_pass & (qry_pass + 1'b1);

  assign join_prev = |(ins_first[MaxIntervals:1] & eq_prev_vec);
  assign join_next = |(ins_first[MaxIntervals-1:0] & valid_vec & eq_next_vec);
  assign query_hit = |(qry_first[MaxIntervals-1:0] & valid_vec & in_start_vec);
  assign full      = (count_q == CountW'(MaxIntervals));

  // Decide the update, the new count and the result
  always_comb begin
    kind      = UPD_NONE;
    count_d   = count_q;
    hit_d     = 1'b0;
    dropped_d = 1'b0;
    if (commit) begin
      case (op_e'(op_q))
        OP_INSERT: begin
          if (join_prev && join_next) begin
            kind    = UPD_MERGE;
            count_d = CountW'(count_q - 1'b1);
          end else if (join_prev) begin
            kind = UPD_JOIN_PREV;
          end else if (join_next) begin
            kind = UPD_JOIN_NEXT;
          end else if (full) begin
            dropped_d = 1'b1;
          end else begin
            kind    = UPD_INSERT;
            count_d = CountW'(count_q + 1'b1);
          end
        end
        OP_QUERY: begin
          hit_d = query_hit;
        end
        OP_CLEAR: begin
          kind    = UPD_CLEAR;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign ctrl = '{kind: kind, t1: t1_q, t2: t2_q};

  // Row of cells, each linked to both neighbors
  for (genvar i = 0; i < MaxIntervals; i++) begin : g_cell
    cell_data_t left, right;
    cell_pos_t  pos;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cdata[i-1];
    end
    if (i == MaxIntervals - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cdata[i+1];
    end

    assign pos.at_pos    = ins_first[i];
    assign pos.pre_pos   = ins_first[i+1];
    assign pos.after_pos = ~ins_below[i] & ~ins_first[i];

    isiq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .left_i  (left),
      .right_i (right),
      .data_o  (cdata[i]),
      .flags_o (cflags[i])
    );
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture request, load result
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q <= req_i.operation;
      t1_q <= req_i.start_req;
      t2_q <= req_i.stop;
    end
    if (commit) begin
      hit_q         <= hit_d;
      dropped_q     <= dropped_d;
      entry_count_q <= COUNT_OUT_W'(count_d);
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.hit          = hit_q;
  assign rsp_o.dropped_full = dropped_q;
  assign rsp_o.entry_count  = entry_count_q;

  // Occupied cells always match the count
  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == count_q)
    else $error("occupied cells differ from entry count");

  // A drop happens only with a full table
  a_drop_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && dropped_d |-> full)
    else $error("insert dropped with free entries");

  // Clear empties the table
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && (op_q == OP_CLEAR) |=> count_q == '0)
    else $error("clear left entries");

  // No request taken during the compare cycle
  a_no_accept_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CMP |-> !req_i.ready)
    else $error("request taken during compare");

  // Hit and drop never reported together
  a_hit_xor_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(hit_q && dropped_q))
    else $error("hit and drop both set");

endmodule

// File: src/isiq_cell.sv
module isiq_cell import isiq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  cell_pos_t   pos_i,
  input  cell_data_t  left_i,
  input  cell_data_t  right_i,
  output cell_data_t  data_o,
  output cell_flags_t flags_o
);

  logic        valid_q, valid_d;
  span_t       span_q, span_d;
  cell_flags_t flags_q, flags_d;
  logic [TIME_W:0] stop_inc;
  logic [TIME_W:0] t2_inc;

  // Compare the held interval against the request times
  always_comb begin
    stop_inc = {1'b0, span_q.stop} + 1'b1;
    t2_inc   = {1'b0, ctrl_i.t2} + 1'b1;
    flags_d.valid    = valid_q;
    flags_d.pass_ins = valid_q && !(ctrl_i.t2 < span_q.start);
    flags_d.pass_qry = valid_q && (ctrl_i.t1 > span_q.stop);
    flags_d.in_start = (ctrl_i.t1 >= span_q.start);
    flags_d.eq_prev  = ({1'b0, ctrl_i.t1} == stop_inc);
    flags_d.eq_next  = (t2_inc == {1'b0, span_q.start});
  end

  // Select the next content: keep, clear, take a neighbor, or load request times
  always_comb begin
    valid_d = valid_q;
    span_d  = span_q;
    case (ctrl_i.kind)
      UPD_CLEAR: begin
        valid_d = 1'b0;
      end
      UPD_INSERT: begin
        if (pos_i.at_pos) begin
          valid_d = 1'b1;
          span_d  = '{start: ctrl_i.t1, stop: ctrl_i.t2};
        end else if (pos_i.after_pos) begin
          valid_d = left_i.valid;
          span_d  = left_i.span;
        end
      end
      UPD_JOIN_PREV: begin
        if (pos_i.pre_pos) span_d.stop = ctrl_i.t2;
      end
      UPD_JOIN_NEXT: begin
        if (pos_i.at_pos) span_d.start = ctrl_i.t1;
      end
      UPD_MERGE: begin
        if (pos_i.pre_pos) begin
          span_d.stop = right_i.span.stop;
        end else if (pos_i.at_pos || pos_i.after_pos) begin
          valid_d = right_i.valid;
          span_d  = right_i.span;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the occupancy bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold interval times and compare flags
  always_ff @(posedge clk_i) begin
    span_q  <= span_d;
    flags_q <= flags_d;
  end

  assign data_o  = '{valid: valid_q, span: span_q};
  assign flags_o = flags_q;

endmodule

// File: bench/testbench.sv
module testbench;
  import isiq_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_INTERVALS_DEF;
  localparam int TIME_MAX = (1 << TIME_W) - 1;
  // Selector value with no operation behind it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic                   hit;
    logic                   dropped_full;
    logic [COUNT_OUT_W-1:0] entry_count;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  isiq_req_if req_if ();
  isiq_rsp_if rsp_if ();

  interval_set_insert_query_unit #(
    .MaxIntervals(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the interval table
  span_t       stored_spans [TABLE_DEPTH];
  int unsigned stored_count;

  outcome_t pending_outcomes [$];

  bit          idling_on;
  int unsigned fail_count;
  int unsigned results_checked;
  int unsigned inserts_sent, drops_seen, queries_sent, hits_seen, clears_sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Apply one request to the shadow table and return the outcome it must produce
  function automatic outcome_t apply_to_table(logic [OP_W-1:0] op, logic [TIME_W-1:0] t1,
                                              logic [TIME_W-1:0] t2);
    outcome_t    res;
    int unsigned pos;
    int unsigned k;
    bit          join_prev;
    bit          join_next;
    res = '0;
    case (op)
      OP_INSERT: begin
        pos = 0;
        while (pos < stored_count && !(t2 < stored_spans[pos].start)) pos++;
        // adjacency is checked one bit wider, so the top of range never wraps
        join_prev = (pos > 0) && (int'(t1) == int'(stored_spans[pos-1].stop) + 1);
        join_next = (pos < stored_count) && (int'(t2) + 1 == int'(stored_spans[pos].start));
        if (join_prev) stored_spans[pos-1].stop = t2;
        if (join_next) stored_spans[pos].start = t1;
        if (join_prev && join_next) begin
          // fold the successor into the predecessor and close the hole
          stored_spans[pos-1].stop = stored_spans[pos].stop;
          for (k = pos; k + 1 < stored_count; k++) stored_spans[k] = stored_spans[k+1];
          stored_count--;
        end else if (!join_prev && !join_next) begin
          if (stored_count >= TABLE_DEPTH) begin
            res.dropped_full = 1'b1;
          end else begin
            for (k = stored_count; k > pos; k--) stored_spans[k] = stored_spans[k-1];
            stored_spans[pos].start = t1;
            stored_spans[pos].stop  = t2;
            stored_count++;
          end
        end
      end
      OP_QUERY: begin
        for (k = 0; k < stored_count; k++) begin
          if (t1 <= stored_spans[k].stop) begin
            res.hit = (t1 >= stored_spans[k].start);
            break;
          end
        end
      end
      OP_CLEAR: stored_count = 0;
      default: ;
    endcase
    res.entry_count = COUNT_OUT_W'(stored_count);
    return res;
  endfunction

  // Send one request, holding valid across back-to-back transactions
  task automatic send_op(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t1,
                         input logic [TIME_W-1:0] t2);
    outcome_t res;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.start_req <= t1;
    req_if.stop      <= t2;
    do @(posedge clk_i); while (!req_if.ready);
    res = apply_to_table(op, t1, t2);
    pending_outcomes.push_back(res);
    case (op)
      OP_INSERT: begin
        inserts_sent++;
        drops_seen += res.dropped_full;
      end
      OP_QUERY: begin
        queries_sent++;
        hits_seen += res.hit;
      end
      OP_CLEAR: clears_sent++;
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Compare every result transaction with the oldest pending outcome
  always @(posedge clk_i) begin
    outcome_t exp_res;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        note_failure($sformatf("result with nothing pending: hit=%0b dropped_full=%0b count=%0d",
                               rsp_if.hit, rsp_if.dropped_full, rsp_if.entry_count));
      end else begin
        exp_res = pending_outcomes.pop_front();
        if (rsp_if.hit !== exp_res.hit || rsp_if.dropped_full !== exp_res.dropped_full ||
            rsp_if.entry_count !== exp_res.entry_count) begin
          note_failure($sformatf({"result %0d: expected hit=%0b dropped_full=%0b count=%0d, ",
                                  "got hit=%0b dropped_full=%0b count=%0d"},
                                 results_checked, exp_res.hit, exp_res.dropped_full,
                                 exp_res.entry_count, rsp_if.hit, rsp_if.dropped_full,
                                 rsp_if.entry_count));
        end
      end
      results_checked++;
    end
  end

  // Stall the result channel in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 8);
      rsp_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Query an empty table, the unused selector and a clear with nothing stored
  task automatic test_empty_table();
    send_op(OP_QUERY, '0, '0);
    send_op(OP_QUERY, TIME_W'(TIME_MAX), '0);
    send_op(OP_UNUSED, '1, '1);
    send_op(OP_UNUSED, '0, '0);
    send_op(OP_CLEAR, '1, '0);
  endtask

  // Full-range interval, and a stop at the top that must not look adjacent to zero
  task automatic test_range_extremes();
    send_op(OP_INSERT, '0, TIME_W'(TIME_MAX));
    send_op(OP_INSERT, '0, TIME_W'(10));
    send_op(OP_QUERY, '0, '1);
    send_op(OP_QUERY, TIME_W'(TIME_MAX), '0);
    send_op(OP_CLEAR, '0, '0);
  endtask

  // Start above stop is stored as given
  task automatic test_reversed_interval();
    send_op(OP_INSERT, TIME_W'(300), TIME_W'(200));
    send_op(OP_QUERY, TIME_W'(250), '0);
    send_op(OP_QUERY, TIME_W'(200), '0);
    send_op(OP_INSERT, TIME_W'(201), TIME_W'(250));
    send_op(OP_QUERY, TIME_W'(220), '0);
  endtask

  // Fill the table, then drop, join on either side and merge while full
  task automatic test_full_table();
    int unsigned i;
    send_op(OP_CLEAR, '0, '0);
    for (i = 0; i < TABLE_DEPTH; i++)
      send_op(OP_INSERT, TIME_W'(i * 2000 + 100), TIME_W'(i * 2000 + 199));
    send_op(OP_INSERT, TIME_W'(30000), TIME_W'(30010));
    send_op(OP_INSERT, TIME_W'(200), TIME_W'(299));
    send_op(OP_INSERT, TIME_W'(2050), TIME_W'(2099));
    send_op(OP_INSERT, TIME_W'(4200), TIME_W'(6099));
    send_op(OP_INSERT, TIME_W'(TIME_MAX), TIME_W'(TIME_MAX));
    send_op(OP_QUERY, TIME_W'(5000), '0);
    send_op(OP_QUERY, TIME_W'(2000), '0);
  endtask

  function automatic int pick_time(bit narrow);
    return narrow ? int'($urandom_range(0, 511)) : int'($urandom_range(0, TIME_MAX));
  endfunction

  // Inserts built around stored entries and queries near their edges, plus clears and unused selectors
  task automatic test_random_mix(input int unsigned item_total);
    int unsigned n;
    int unsigned k;
    int          sel;
    int          a;
    int          b;
    int          len;
    bit          narrow;
    for (n = 0; n < item_total; n++) begin
      idling_on = ((n / 50) % 2 == 0) && (n + 100 < item_total);
      narrow    = $urandom_range(0, 1);
      sel       = $urandom_range(0, 99);
      a         = pick_time(narrow);
      len       = $urandom_range(0, narrow ? 20 : 3000);
      b         = a + len;
      if (sel < 3) begin
        send_op(OP_CLEAR, TIME_W'(pick_time(0)), TIME_W'(pick_time(0)));
      end else if (sel < 5) begin
        send_op(OP_UNUSED, TIME_W'(pick_time(0)), TIME_W'(pick_time(0)));
      end else if (sel < 52) begin
        if (stored_count > 0) begin
          k = $urandom_range(0, stored_count - 1);
          case ($urandom_range(0, 3))
            0: if (stored_spans[k].stop < TIME_MAX) begin
              a = int'(stored_spans[k].stop) + 1;
              b = a + len;
            end
            1: if (stored_spans[k].start > 0) begin
              b = int'(stored_spans[k].start) - 1;
              a = b - len;
            end
            2: if (k + 1 < stored_count && stored_spans[k].stop < TIME_MAX &&
                   stored_spans[k+1].start > 0) begin
              a = int'(stored_spans[k].stop) + 1;
              b = int'(stored_spans[k+1].start) - 1;
            end
            default: ;
          endcase
        end
        if (a < 0) a = 0;
        if (b > TIME_MAX) b = TIME_MAX;
        if ($urandom_range(0, 15) == 0) begin
          len = a;
          a   = b;
          b   = len;
        end
        send_op(OP_INSERT, TIME_W'(a), TIME_W'(b));
      end else begin
        if (stored_count > 0 && $urandom_range(0, 2) != 0) begin
          k = $urandom_range(0, stored_count - 1);
          case ($urandom_range(0, 4))
            0: a = int'(stored_spans[k].start) - 1;
            1: a = int'(stored_spans[k].start);
            2: a = int'(stored_spans[k].stop);
            3: a = int'(stored_spans[k].stop) + 1;
            default: a = (int'(stored_spans[k].start) + int'(stored_spans[k].stop)) / 2;
          endcase
          if (a < 0) a = 0;
          if (a > TIME_MAX) a = TIME_MAX;
        end
        send_op(OP_QUERY, TIME_W'(a), TIME_W'(pick_time(0)));
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_CLEAR;
    req_if.start_req <= '0;
    req_if.stop      <= '0;
    idling_on        = 1'b1;
    stored_count     = 0;
    fail_count       = 0;
    results_checked  = 0;
    inserts_sent     = 0;
    drops_seen       = 0;
    queries_sent     = 0;
    hits_seen        = 0;
    clears_sent      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_range_extremes();
    test_reversed_interval();
    test_full_table();
    test_random_mix(610);

    // Drain outstanding results, then keep watching for strays
    req_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts (%0d dropped on a full table), %0d queries",
             results_checked, inserts_sent, drops_seen, queries_sent);
    $display("  with %0d hits, %0d clears; %0d mismatches", hits_seen, clears_sent, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Abort a hung run
  initial begin
    #400000;
    $display("Timeout with %0d results outstanding", pending_outcomes.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/isiq_pkg.sv
src/isiq_if.sv
src/isiq_cell.sv
src/interval_set_insert_query_unit.sv
bench/testbench.sv
